// ===== sv/ptdrt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdrt_pkg: shared types and constants of the sound register translator
// Register offsets of the target sound unit, the word types passed between
// the stages, the period-to-frequency reciprocal and small mapping functions.
// ----------------------------------------------------------------------------
package ptdrt_pkg;

  // Source chip clock in Hz. The period scale is 2^22 over this clock for the
  // square channels and half of that for the wave channel.
  localparam longint unsigned SrcClkHz = 64'd3579545;
  localparam int unsigned     PeriodW  = 10;
  localparam int unsigned     QuotW    = 11;
  localparam int unsigned     FreqW    = 12;

  // floor(n * 2^22 / SrcClkHz) == (n * RecipMul) >> RecipShift for every
  // 10-bit n: the rounding error of the ceiling stays below 1 / SrcClkHz.
  localparam int unsigned     RecipShift = 32;
  localparam int unsigned     RecipW     = 33;
  localparam logic [RecipW-1:0] RecipMul =
    RecipW'(((64'd1 << (22 + RecipShift)) + SrcClkHz - 64'd1) / SrcClkHz);
  localparam int unsigned     ProdW      = RecipW + PeriodW;

  // Target register offsets
  localparam logic [4:0] OffSq1Env     = 5'h02;
  localparam logic [4:0] OffSq1FreqLo  = 5'h03;
  localparam logic [4:0] OffSq1FreqHi  = 5'h04;
  localparam logic [4:0] OffSq2Env     = 5'h07;
  localparam logic [4:0] OffSq2FreqLo  = 5'h08;
  localparam logic [4:0] OffSq2FreqHi  = 5'h09;
  localparam logic [4:0] OffWaveLevel  = 5'h0C;
  localparam logic [4:0] OffWaveFreqLo = 5'h0D;
  localparam logic [4:0] OffWaveFreqHi = 5'h0E;
  localparam logic [4:0] OffNoiseEnv   = 5'h11;
  localparam logic [4:0] OffNoisePoly  = 5'h12;
  localparam logic [4:0] OffNoiseCtrl  = 5'h13;
  localparam logic [4:0] OffLast       = 5'h16;

  localparam logic [7:0] TriggerBit = 8'h80;
  localparam logic [7:0] EnvUpBit   = 8'h08;

  localparam logic [1:0] ChSq1   = 2'd0;
  localparam logic [1:0] ChSq2   = 2'd1;
  localparam logic [1:0] ChWave  = 2'd2;
  localparam logic [1:0] ChNoise = 2'd3;

  typedef struct packed {
    logic [1:0]         ch;
    logic               is_vol;
    logic [PeriodW-1:0] period;
    logic [3:0]         att;
    logic [2:0]         noise;
  } job_t;

  typedef struct packed {
    logic [4:0] offset;
    logic [7:0] value;
  } wr_t;

  typedef wr_t wlist_t [3];

  function automatic logic [7:0] env_byte(input logic [3:0] att);
    logic [3:0] vol;
    vol = 4'hF - att;
    return {vol, 4'h0} | EnvUpBit;
  endfunction

  function automatic logic [7:0] wave_level(input logic [3:0] att);
    logic [7:0] lvl;
    priority if (att == 4'd15) lvl = 8'h00;
    else if (att >= 4'd10)     lvl = 8'h60;
    else if (att >= 4'd5)      lvl = 8'h40;
    else                       lvl = 8'h20;
    return lvl;
  endfunction

  function automatic logic [7:0] noise_poly(input logic [2:0] ctrl);
    logic [7:0] shift;
    logic [7:0] width;
    unique case (ctrl[1:0])
      2'd0:    shift = 8'h00;
      2'd1:    shift = 8'h30;
      2'd2:    shift = 8'h60;
      default: shift = 8'h40;
    endcase
    width = ctrl[2] ? 8'h00 : 8'h08;
    return shift | width;
  endfunction

endpackage

// ===== sv/psg_to_dmg_register_translator.sv =====
// ----------------------------------------------------------------------------
// psg_to_dmg_register_translator: sound chip write translator
// Takes write bytes of a four-channel square/noise chip and emits the
// register writes of a handheld-style sound unit.
// ----------------------------------------------------------------------------
// Each accepted byte yields one to three output words (offset, value), the
// final one flagged by out_tlast. The channel state and the job register
// update at the accepting edge; the period scaling multiply then feeds the
// second stage register, and the write list builder feeds the word list
// register that drives the output. Words leave at one per cycle while
// out_tready is high; bytes are taken while earlier words drain.
module psg_to_dmg_register_translator
  import ptdrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] psg_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [4:0] reg_offset, [12:5] reg_value, [15:13] zero
  output logic        out_tlast
);

  logic             in_fire, out_fire, out_done;
  logic             wl_free, s2_free;

  logic             s1_vld_r, s1_vld_nxt;
  job_t             s1_job_r;
  job_t             dec_job;

  logic             s2_vld_r, s2_vld_nxt;
  job_t             s2_job_r;
  logic [QuotW-1:0] s2_quot_r;
  logic [ProdW-1:0] prod;

  logic             wl_vld_r, wl_vld_nxt;
  wlist_t           wl_r;
  wlist_t           enc_list;
  logic [1:0]       enc_last;
  logic [1:0]       last_idx_r;
  logic [1:0]       idx_r, idx_nxt;

  assign out_fire = out_tvalid & out_tready;
  assign out_done = out_fire & out_tlast;
  assign wl_free  = !wl_vld_r | out_done;
  assign s2_free  = !s2_vld_r | wl_free;
  assign in_tready = !s1_vld_r | s2_free;
  assign in_fire  = in_tvalid & in_tready;

  ptdrt_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (in_fire),
    .psg_byte (in_tdata),
    .job      (dec_job)
  );

  always_ff @(posedge clk) begin
    if (in_fire) s1_job_r <= dec_job;
  end

  // Scaled period: floor(n * 2^22 / source clock) by reciprocal multiply.
  assign prod = ProdW'(s1_job_r.period) * ProdW'(RecipMul);

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_job_r  <= s1_job_r;
      s2_quot_r <= prod[RecipShift +: QuotW];
    end
  end

  ptdrt_encode u_encode (
    .job      (s2_job_r),
    .quot     (s2_quot_r),
    .wlist    (enc_list),
    .last_idx (enc_last)
  );

  always_ff @(posedge clk) begin
    if (wl_free) begin
      wl_r       <= enc_list;
      last_idx_r <= enc_last;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_fire)      s1_vld_nxt = 1'b1;
    else if (s2_free) s1_vld_nxt = 1'b0;

    s2_vld_nxt = s2_free ? s1_vld_r : s2_vld_r;
    wl_vld_nxt = wl_free ? s2_vld_r : wl_vld_r;

    idx_nxt = idx_r;
    if (wl_free)       idx_nxt = 2'd0;
    else if (out_fire) idx_nxt = idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      wl_vld_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      wl_vld_r <= wl_vld_nxt;
      idx_r    <= idx_nxt;
    end
  end

  assign out_tvalid = wl_vld_r;
  assign out_tdata  = {3'b000, wl_r[idx_r].value, wl_r[idx_r].offset};
  assign out_tlast  = (idx_r == last_idx_r);

endmodule

// ===== sv/ptdrt_decode.sv =====
// ----------------------------------------------------------------------------
// ptdrt_decode: latch and channel state of the source chip
// Holds the latched channel and type, the tone periods, the attenuations and
// the noise control, updates them on each accepted byte and presents the
// updated values of the addressed channel as a job.
// ----------------------------------------------------------------------------
module ptdrt_decode
  import ptdrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] psg_byte,
  output job_t       job
);

  logic [1:0]         lch_r, lch_nxt;
  logic               lvol_r, lvol_nxt;
  logic [PeriodW-1:0] period_r [3];
  logic [PeriodW-1:0] period_nxt [3];
  logic [3:0]         att_r [4];
  logic [3:0]         att_nxt [4];
  logic [2:0]         noise_r, noise_nxt;

  always_comb begin
    lch_nxt  = psg_byte[7] ? psg_byte[6:5] : lch_r;
    lvol_nxt = psg_byte[7] ? psg_byte[4]   : lvol_r;
    period_nxt = period_r;
    att_nxt    = att_r;
    noise_nxt  = noise_r;

    if (lvol_nxt) begin
      att_nxt[lch_nxt] = psg_byte[3:0];
    end else if (lch_nxt == ChNoise) begin
      noise_nxt = psg_byte[2:0];
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (lch_nxt == 2'(i)) begin
          // A latch byte carries the low nibble, a data byte the upper six bits.
          if (psg_byte[7]) period_nxt[i][3:0] = psg_byte[3:0];
          else             period_nxt[i][9:4] = psg_byte[5:0];
        end
      end
    end

    job.ch     = lch_nxt;
    job.is_vol = lvol_nxt;
    job.att    = att_nxt[lch_nxt];
    job.noise  = noise_nxt;
    job.period = '0;
    for (int i = 0; i < 3; i++) begin
      if (lch_nxt == 2'(i)) job.period = period_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lch_r   <= ChSq1;
      lvol_r  <= 1'b0;
      noise_r <= '0;
      for (int i = 0; i < 3; i++) period_r[i] <= '0;
      for (int i = 0; i < 4; i++) att_r[i] <= 4'hF;
    end else if (en) begin
      lch_r    <= lch_nxt;
      lvol_r   <= lvol_nxt;
      noise_r  <= noise_nxt;
      period_r <= period_nxt;
      att_r    <= att_nxt;
    end
  end

endmodule

// ===== sv/ptdrt_encode.sv =====
// ----------------------------------------------------------------------------
// ptdrt_encode: target register write list builder
// Turns one job and its scaled period into the one to three register writes
// of the target sound unit, in order, with the index of the final write.
// ----------------------------------------------------------------------------
module ptdrt_encode
  import ptdrt_pkg::*;
(
  input  job_t             job,
  input  logic [QuotW-1:0] quot,
  output wlist_t           wlist,
  output logic [1:0]       last_idx
);

  logic [FreqW-1:0] f_sq;
  logic [FreqW-1:0] f_wave;
  logic [7:0]       env;
  logic [4:0]       base;

  // The quotient never exceeds 2047, so no clamp to zero is ever needed.
  always_comb begin
    if (job.period == '0) begin
      f_sq   = FreqW'(2047);
      f_wave = FreqW'(2047);
    end else begin
      f_sq   = FreqW'(2048) - {1'b0, quot};
      f_wave = FreqW'(2048) - {2'b00, quot[QuotW-1:1]};
    end
  end

  assign env  = env_byte(job.att);
  assign base = (job.ch == ChSq1) ? OffSq1Env : OffSq2Env;

  always_comb begin
    for (int i = 0; i < 3; i++) wlist[i] = '0;
    last_idx = 2'd0;
    unique case (job.ch)
      ChNoise: begin
        wlist[0] = '{offset: OffNoiseEnv,  value: env};
        wlist[1] = '{offset: OffNoisePoly, value: noise_poly(job.noise)};
        wlist[2] = '{offset: OffNoiseCtrl, value: TriggerBit};
        last_idx = 2'd2;
      end
      ChWave: begin
        if (job.is_vol) begin
          wlist[0] = '{offset: OffWaveLevel, value: wave_level(job.att)};
          last_idx = 2'd0;
        end else begin
          wlist[0] = '{offset: OffWaveFreqLo, value: f_wave[7:0]};
          wlist[1] = '{offset: OffWaveFreqHi, value: TriggerBit | {5'b0, f_wave[10:8]}};
          last_idx = 2'd1;
        end
      end
      default: begin
        // Both square channels share one layout, five registers apart.
        if (job.is_vol) wlist[0] = '{offset: base, value: env};
        else            wlist[0] = '{offset: base + 5'd1, value: f_sq[7:0]};
        wlist[1] = '{offset: base + 5'd2, value: TriggerBit | {5'b0, f_sq[10:8]}};
        last_idx = 2'd1;
      end
    endcase
  end

endmodule

// ===== sv/ptdrt_checker.sv =====
// ----------------------------------------------------------------------------
// ptdrt_checker: port-level checks of the sound register translator
// Watches the top-level ports and flags words that break the output rules.
// ----------------------------------------------------------------------------
module ptdrt_checker
  import ptdrt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= OffLast && out_tdata[15:13] == 3'b000)
    else $error("register offset out of range");

  a_noise_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == OffNoiseCtrl |-> out_tlast && out_tdata[12:5] == TriggerBit)
    else $error("noise trigger word malformed");

  // The noise envelope word is always followed at once by the noise polynomial.
  a_noise_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[4:0] == OffNoiseEnv
    |-> !out_tlast ##1 out_tvalid && out_tdata[4:0] == OffNoisePoly)
    else $error("noise writes out of order");

endmodule

bind psg_to_dmg_register_translator ptdrt_checker u_ptdrt_checker (.*);

// ===== tb/sv/psg_to_dmg_register_translator_tb.sv =====
// ----------------------------------------------------------------------------
// psg_to_dmg_register_translator_tb: self-checking bench of the write translator
// Feeds source chip write bytes, directed and random, under several patterns
// of input gaps and output back-pressure. It predicts the register writes of
// the target sound unit for every accepted byte and compares each output word
// in order against them.
// ----------------------------------------------------------------------------
module psg_to_dmg_register_translator_tb;
  import ptdrt_pkg::*;

  localparam longint unsigned SrcClock    = 64'd3579545;
  localparam longint unsigned SquareScale = 64'd4194304;
  localparam longint unsigned WaveScale   = 64'd2097152;
  localparam int              SettleCycles = 8;
  localparam int              DrainLimit   = 20000;
  localparam int              PrintLimit   = 40;

  typedef struct packed {
    logic [4:0] offset;
    logic [7:0] value;
    logic       last;
  } snd_write_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] psg_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [4:0] reg_offset, [12:5] reg_value, [15:13] zero
  logic        out_tlast;

  // Predicted chip state
  logic [1:0]  latch_ch;
  logic        latch_vol;
  logic [9:0]  tone_per [3];
  logic [3:0]  chan_att [4];
  logic [2:0]  noise_ctrl;

  snd_write_t  pending_writes [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;

  psg_to_dmg_register_translator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [10:0] period_to_freq(input logic [9:0] n,
                                                 input longint unsigned scale);
    longint unsigned quot;
    quot = (scale * 64'(n)) / SrcClock;
    if (n == 10'd0) return 11'd2047;
    if (quot >= 64'd2048) return 11'd0;
    return 11'(64'd2048 - quot);
  endfunction

  function automatic void push_write(input logic [4:0] off, input logic [7:0] val,
                                     input logic last);
    pending_writes.push_back('{offset: off, value: val, last: last});
  endfunction

  function automatic void predict_writes(input logic [7:0] b);
    logic [1:0]  ch;
    logic [3:0]  vol;
    logic [10:0] freq;
    logic [7:0]  lvl;
    logic [7:0]  shift;
    logic [7:0]  width;
    if (b[7]) begin
      latch_ch  = b[6:5];
      latch_vol = b[4];
    end
    ch = latch_ch;
    // A tone byte on the noise channel, latch or data alike, sets the noise control.
    if (latch_vol) begin
      chan_att[ch] = b[3:0];
    end else if (ch == ChNoise) begin
      noise_ctrl = b[2:0];
    end else if (b[7]) begin
      tone_per[ch][3:0] = b[3:0];
    end else begin
      tone_per[ch][9:4] = b[5:0];
    end

    vol = 4'hF - chan_att[ch];
    case (ch)
      ChNoise: begin
        width = noise_ctrl[2] ? 8'h00 : 8'h08;
        case (noise_ctrl[1:0])
          2'd0:    shift = 8'h00;
          2'd1:    shift = 8'h30;
          2'd2:    shift = 8'h60;
          default: shift = 8'h40;
        endcase
        push_write(OffNoiseEnv, {vol, 4'h0} | EnvUpBit, 1'b0);
        push_write(OffNoisePoly, shift | width, 1'b0);
        push_write(OffNoiseCtrl, TriggerBit, 1'b1);
      end
      ChWave: begin
        if (latch_vol) begin
          if (chan_att[ChWave] == 4'd15)     lvl = 8'h00;
          else if (chan_att[ChWave] >= 4'd10) lvl = 8'h60;
          else if (chan_att[ChWave] >= 4'd5)  lvl = 8'h40;
          else                                lvl = 8'h20;
          push_write(OffWaveLevel, lvl, 1'b1);
        end else begin
          freq = period_to_freq(tone_per[ChWave], WaveScale);
          push_write(OffWaveFreqLo, freq[7:0], 1'b0);
          push_write(OffWaveFreqHi, TriggerBit | {5'd0, freq[10:8]}, 1'b1);
        end
      end
      default: begin
        freq = period_to_freq(tone_per[ch], SquareScale);
        if (latch_vol)
          push_write((ch == ChSq1) ? OffSq1Env : OffSq2Env, {vol, 4'h0} | EnvUpBit, 1'b0);
        else
          push_write((ch == ChSq1) ? OffSq1FreqLo : OffSq2FreqLo, freq[7:0], 1'b0);
        push_write((ch == ChSq1) ? OffSq1FreqHi : OffSq2FreqHi,
                   TriggerBit | {5'd0, freq[10:8]}, 1'b1);
      end
    endcase
  endfunction

  // Each output word is checked against the oldest predicted write.
  always @(posedge clk) begin : check_words
    snd_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
      end else begin
        want = pending_writes.pop_front();
        if (out_tdata[4:0] !== want.offset)
          report_mismatch($sformatf("offset %h, wanted %h", out_tdata[4:0], want.offset));
        if (out_tdata[12:5] !== want.value)
          report_mismatch($sformatf("value %h at offset %h, wanted %h",
                                    out_tdata[12:5], want.offset, want.value));
        if (out_tdata[15:13] !== 3'd0)
          report_mismatch($sformatf("padding bits %b not zero", out_tdata[15:13]));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b at offset %h, wanted %b",
                                    out_tlast, want.offset, want.last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_writes(b);
  endtask

  // Holds the input off until every predicted write has come out.
  task automatic wait_all_results();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    if (pending_writes.size() != 0)
      report_mismatch($sformatf("%0d writes never arrived", pending_writes.size()));
    pending_writes.delete();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Field extremes, every channel and type, period limits, wave level thresholds,
  // ignored data bits, and tone bytes on the noise channel.
  task automatic test_directed_bytes();
    logic [7:0] seq [25];
    seq = '{8'h7F, 8'h8F, 8'h80, 8'h00, 8'h90, 8'h7F, 8'hA5, 8'h2A, 8'hB3,
            8'hCF, 8'h3F, 8'h00, 8'hD0, 8'h04, 8'h05, 8'h09, 8'h0A, 8'h0E,
            8'h0F, 8'hE4, 8'h03, 8'h79, 8'hF0, 8'h7F, 8'hE2};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Latch bytes followed by zero to two data bytes, random channel and content.
  task automatic test_register_sequences(input int count);
    int sent;
    int data_bytes;
    sent = 0;
    while (sent < count) begin
      send_byte({1'b1, 2'($urandom_range(3)), 1'($urandom_range(1)),
                 4'($urandom_range(15))});
      sent++;
      data_bytes = $urandom_range(2);
      for (int k = 0; k < data_bytes; k++) begin
        send_byte({1'b0, 7'($urandom_range(127))});
        sent++;
      end
    end
  endtask

  task automatic test_raw_bytes(input int count);
    for (int k = 0; k < count; k++) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    out_tready <= 1'b0;
    latch_ch   = ChSq1;
    latch_vol  = 1'b0;
    noise_ctrl = 3'd0;
    foreach (tone_per[i]) tone_per[i] = 10'd0;
    foreach (chan_att[i]) chan_att[i] = 4'hF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_bytes();
    wait_all_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      test_register_sequences(75);
      test_raw_bytes(27);
      wait_all_results();
    end

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
